// File: rtl/ladsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladsr_pkg
// Shared types and constants for the linear ADSR envelope block.
// ----------------------------------------------------------------------------
package ladsr_pkg;

  // Default widths
  localparam int DEF_LEVEL_BITS = 16;
  localparam int DEF_TIME_BITS  = 24;

  // Config write data bus width (covers the widest register)
  localparam int CFG_DATA_BITS = 32;

  // Register reset values
  localparam int ATTACK_RST  = 480;
  localparam int DECAY_RST   = 4800;
  localparam int SUSTAIN_RST = 45875;
  localparam int RELEASE_RST = 9600;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_RESET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PREP,
    CS_DIV_INIT,
    CS_DIV,
    CS_APPLY,
    CS_GAIN,
    CS_OUT
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic start;     // request accepted this cycle
    logic prep;      // load step product, settle non-dividing cases
    logic div_init;  // load divider from product
    logic div_step;  // one quotient bit
    logic apply;     // commit quotient to envelope state
    logic mul_gain;  // load level * velocity product
    logic load_out;  // fill output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } ctrl_status_t;

endpackage

// File: rtl/ladsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladsr_ctrl
// Sequencer for the envelope datapath and output register handshake.
// ----------------------------------------------------------------------------
module ladsr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  ladsr_pkg::ctrl_status_t status_i,
  output ladsr_pkg::ctrl_cmd_t    cmd_o
);

  ladsr_pkg::ctrl_state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ladsr_pkg::CS_IDLE: begin
        if (in_valid_i) state_d = ladsr_pkg::CS_PREP;
      end
      ladsr_pkg::CS_PREP: begin
        state_d = status_i.need_div ? ladsr_pkg::CS_DIV_INIT : ladsr_pkg::CS_GAIN;
      end
      ladsr_pkg::CS_DIV_INIT: state_d = ladsr_pkg::CS_DIV;
      ladsr_pkg::CS_DIV: begin
        if (status_i.div_done) state_d = ladsr_pkg::CS_APPLY;
      end
      ladsr_pkg::CS_APPLY: state_d = ladsr_pkg::CS_GAIN;
      ladsr_pkg::CS_GAIN:  state_d = ladsr_pkg::CS_OUT;
      ladsr_pkg::CS_OUT: begin
        if (out_free) state_d = ladsr_pkg::CS_IDLE;
      end
      default: state_d = ladsr_pkg::CS_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ladsr_pkg::CS_IDLE:     cmd_o.start    = in_valid_i;
      ladsr_pkg::CS_PREP:     cmd_o.prep     = 1'b1;
      ladsr_pkg::CS_DIV_INIT: cmd_o.div_init = 1'b1;
      ladsr_pkg::CS_DIV:      cmd_o.div_step = !status_i.div_done;
      ladsr_pkg::CS_APPLY:    cmd_o.apply    = 1'b1;
      ladsr_pkg::CS_GAIN:     cmd_o.mul_gain = 1'b1;
      ladsr_pkg::CS_OUT:      cmd_o.load_out = out_free;
      default:                cmd_o        = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ladsr_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ladsr_pkg::CS_IDLE);
  assign out_valid_o = out_valid_q;

  // Never overwrite a result that is still being held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_out && out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // A loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  // An accepted request always starts with the prep step
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ladsr_pkg::CS_IDLE && in_valid_i) |=> state_q == ladsr_pkg::CS_PREP)
    else $error("accepted request did not enter prep");

  // Quotient is committed only after the divider finished
  a_apply_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ladsr_pkg::CS_APPLY) |-> $past(status_i.div_done))
    else $error("apply before division done");

endmodule

// File: rtl/ladsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladsr_dp
// Envelope state, config registers, shared multiplier, radix-2 divider and
// output register.
// ----------------------------------------------------------------------------
module ladsr_dp #(
  parameter int LEVEL_BITS = ladsr_pkg::DEF_LEVEL_BITS,
  parameter int TIME_BITS  = ladsr_pkg::DEF_TIME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ladsr_pkg::ctrl_cmd_t              cmd_i,
  output ladsr_pkg::ctrl_status_t           status_o,
  input  logic                              cfg_valid_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [ladsr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [1:0]                        operation_i,
  input  logic [LEVEL_BITS-1:0]             note_velocity_i,
  output logic [LEVEL_BITS-1:0]             env_level_o,
  output logic [LEVEL_BITS-1:0]             voice_gain_o,
  output logic [2:0]                        env_stage_o,
  output logic                              voice_active_o
);

  localparam int L  = LEVEL_BITS;
  localparam int T  = TIME_BITS;
  localparam int MB = (L > T) ? L : T;     // multiplier B operand width
  localparam int PW = L + MB;              // product width
  localparam int N  = L + T;               // dividend width
  localparam int CW = $clog2(N + 1);
  localparam logic [L-1:0] FULL     = '1;
  localparam logic [T-1:0] TIME_MAX = '1;
  localparam int SILENCE_I = ((2 ** L) - 1) / 1000;
  localparam logic [L-1:0] SILENCE  = L'(SILENCE_I);
  localparam logic [CW-1:0] DIV_CNT = CW'(N);

  // Config registers
  logic [T-1:0] attack_q, decay_q, release_q;
  logic [L-1:0] sustain_q;

  // Envelope state
  ladsr_pkg::stage_e stage_q, stage_d;
  logic [L-1:0] level_q, level_d;
  logic [T-1:0] elapsed_q, elapsed_d;
  logic [L-1:0] rel_start_q, rel_start_d;
  logic [L-1:0] vel_q, vel_d;
  logic         active_q, active_d;
  logic         tick_q, tick_d;

  // Arithmetic
  logic [L-1:0]  mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] mul_q;
  logic [N-1:0]  quo_q;
  logic [T-1:0]  rem_q;
  logic [CW-1:0] cnt_q;
  logic [T-1:0]  divisor;
  logic [T:0]    rem_sh;
  logic          rem_ge;
  logic [L-1:0]  span;
  logic          rel_live;
  logic          need_div;
  logic [L-1:0]  dec_drop, dec_lvl;

  // Output register
  logic [L-1:0] out_level_q, out_gain_q;
  logic [2:0]   out_stage_q;
  logic         out_active_q;

  assign span     = FULL - sustain_q;
  assign rel_live = (elapsed_q < release_q);

  always_comb begin
    need_div = 1'b0;
    divisor  = release_q;
    mul_a    = rel_start_q;
    mul_b    = MB'(release_q - elapsed_q);
    unique case (stage_q)
      ladsr_pkg::ST_ATTACK: begin
        need_div = (attack_q != '0);
        divisor  = attack_q;
        mul_a    = FULL;
        mul_b    = MB'(elapsed_q);
      end
      ladsr_pkg::ST_DECAY: begin
        need_div = (decay_q != '0);
        divisor  = decay_q;
        mul_a    = span;
        mul_b    = MB'(elapsed_q);
      end
      ladsr_pkg::ST_RELEASE: begin
        need_div = (release_q != '0) && rel_live;
      end
      default: need_div = 1'b0;
    endcase
    if (cmd_i.mul_gain) begin
      mul_a = level_q;
      mul_b = MB'(vel_q);
    end
  end

  assign status_o.need_div = need_div && tick_q;
  assign status_o.div_done = (cnt_q == '0);

  // Restoring division step
  assign rem_sh = {rem_q, quo_q[N-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor});

  // Decay level from quotient, clamped to the span
  assign dec_drop = (quo_q > N'(span)) ? span : quo_q[L-1:0];
  assign dec_lvl  = FULL - dec_drop;

  always_comb begin
    stage_d     = stage_q;
    level_d     = level_q;
    elapsed_d   = elapsed_q;
    rel_start_d = rel_start_q;
    vel_d       = vel_q;
    active_d    = active_q;
    tick_d      = tick_q;
    if (cmd_i.start) begin
      tick_d = 1'b0;
      unique case (ladsr_pkg::op_e'(operation_i))
        ladsr_pkg::OP_TICK: begin
          tick_d = active_q;
          if (active_q && (elapsed_q != TIME_MAX)) elapsed_d = elapsed_q + 1'b1;
        end
        ladsr_pkg::OP_NOTE_ON: begin
          active_d    = 1'b1;
          vel_d       = note_velocity_i;
          stage_d     = ladsr_pkg::ST_ATTACK;
          level_d     = '0;
          elapsed_d   = '0;
          rel_start_d = '0;
        end
        ladsr_pkg::OP_NOTE_OFF: begin
          if (active_q) begin
            rel_start_d = level_q;
            stage_d     = ladsr_pkg::ST_RELEASE;
            elapsed_d   = '0;
          end
        end
        ladsr_pkg::OP_RESET: begin
          stage_d     = ladsr_pkg::ST_OFF;
          level_d     = '0;
          elapsed_d   = '0;
          rel_start_d = '0;
          vel_d       = '0;
          active_d    = 1'b0;
        end
      endcase
    end else if (cmd_i.prep && tick_q && !need_div) begin
      // zero durations, sustain hold and end of release
      unique case (stage_q)
        ladsr_pkg::ST_ATTACK: begin
          level_d   = FULL;
          stage_d   = ladsr_pkg::ST_DECAY;
          elapsed_d = '0;
        end
        ladsr_pkg::ST_DECAY: begin
          level_d   = sustain_q;
          stage_d   = ladsr_pkg::ST_SUSTAIN;
          elapsed_d = '0;
        end
        ladsr_pkg::ST_SUSTAIN: level_d = sustain_q;
        ladsr_pkg::ST_RELEASE: begin
          level_d  = '0;
          active_d = 1'b0;
          stage_d  = ladsr_pkg::ST_OFF;
        end
        default: level_d = '0;
      endcase
    end else if (cmd_i.apply) begin
      unique case (stage_q)
        ladsr_pkg::ST_ATTACK: begin
          if (quo_q >= N'(FULL)) begin
            level_d   = FULL;
            stage_d   = ladsr_pkg::ST_DECAY;
            elapsed_d = '0;
          end else begin
            level_d = quo_q[L-1:0];
          end
        end
        ladsr_pkg::ST_DECAY: begin
          if (dec_lvl <= sustain_q) begin
            level_d   = sustain_q;
            stage_d   = ladsr_pkg::ST_SUSTAIN;
            elapsed_d = '0;
          end else begin
            level_d = dec_lvl;
          end
        end
        default: begin
          // release: quotient stays below the start level
          if (quo_q[L-1:0] <= SILENCE) begin
            level_d  = '0;
            active_d = 1'b0;
            stage_d  = ladsr_pkg::ST_OFF;
          end else begin
            level_d = quo_q[L-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= T'(ladsr_pkg::ATTACK_RST);
      decay_q     <= T'(ladsr_pkg::DECAY_RST);
      sustain_q   <= L'(ladsr_pkg::SUSTAIN_RST);
      release_q   <= T'(ladsr_pkg::RELEASE_RST);
      stage_q     <= ladsr_pkg::ST_OFF;
      level_q     <= '0;
      elapsed_q   <= '0;
      rel_start_q <= '0;
      vel_q       <= '0;
      active_q    <= 1'b0;
      tick_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (ladsr_pkg::cfg_idx_e'(cfg_index_i))
          ladsr_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i[T-1:0];
          ladsr_pkg::CFG_DECAY:   decay_q   <= cfg_data_i[T-1:0];
          ladsr_pkg::CFG_SUSTAIN: sustain_q <= cfg_data_i[L-1:0];
          ladsr_pkg::CFG_RELEASE: release_q <= cfg_data_i[T-1:0];
        endcase
      end
      stage_q     <= stage_d;
      level_q     <= level_d;
      elapsed_q   <= elapsed_d;
      rel_start_q <= rel_start_d;
      vel_q       <= vel_d;
      active_q    <= active_d;
      tick_q      <= tick_d;
      if (cmd_i.div_init) begin
        cnt_q <= DIV_CNT;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Multiplier, divider and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep || cmd_i.mul_gain) begin
      mul_q <= PW'(mul_a) * PW'(mul_b);
    end
    if (cmd_i.div_init) begin
      quo_q <= mul_q[N-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= T'(rem_sh - {1'b0, divisor});
        quo_q <= {quo_q[N-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[T-1:0];
        quo_q <= {quo_q[N-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_level_q  <= level_q;
      out_gain_q   <= mul_q[2*L-1:L];
      out_stage_q  <= stage_q;
      out_active_q <= active_q;
    end
  end

  assign env_level_o    = out_level_q;
  assign voice_gain_o   = out_gain_q;
  assign env_stage_o    = out_stage_q;
  assign voice_active_o = out_active_q;

endmodule

// File: rtl/linear_adsr_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear attack/decay/sustain/release envelope of one synth voice.
// ----------------------------------------------------------------------------
// Each request (sample tick, note on, note off or reset) yields one result:
// level, gain = (level * velocity) >> LEVEL_BITS, stage and active flag.
// Ticks in attack or decay with a nonzero duration, or in an unfinished
// release, go through the radix-2 restoring divider, which retires one
// quotient bit per cycle. A new request is taken as soon as the previous
// one has been moved into the output register, so the next one runs while
// a result waits to be taken.
// Config writes are accepted every cycle (cfg_ready_o is tied high) and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module linear_adsr_envelope #(
  parameter int LEVEL_BITS = ladsr_pkg::DEF_LEVEL_BITS,
  parameter int TIME_BITS  = ladsr_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [LEVEL_BITS-1:0]               note_velocity_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [LEVEL_BITS-1:0]               env_level_o,
  output logic [LEVEL_BITS-1:0]               voice_gain_o,
  output logic [2:0]                          env_stage_o,
  output logic                                voice_active_o,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [ladsr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  ladsr_pkg::ctrl_cmd_t    cmd;
  ladsr_pkg::ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer: handshakes and step order
  ladsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // envelope state, multiply/divide and output register
  ladsr_dp #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .note_velocity_i (note_velocity_i),
    .env_level_o     (env_level_o),
    .voice_gain_o    (voice_gain_o),
    .env_stage_o     (env_stage_o),
    .voice_active_o  (voice_active_o)
  );

endmodule
